@@ rtl/core/wrol_pkg.sv @@
`timescale 1ns / 1ps

package wrol_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int SIZE_BITS_DEF   = 20;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int OFFSET_BITS     = 24;

  // Command queue between front and back; depth must be a power of two.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic {
    FN_ADD    = 1'b0,
    FN_LOOKUP = 1'b1
  } func_t;

  typedef struct packed {
    logic  valid;
    func_t func;
  } q_head_t;

endpackage

@@ rtl/core/wrol_ram.sv @@
`timescale 1ns / 1ps

module wrol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wrol_front.sv @@
`timescale 1ns / 1ps

module wrol_front import wrol_pkg::*; #(
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [HANDLE_BITS-1:0] in_entry_handle,
  input  logic [SIZE_BITS-1:0]   in_entry_size,
  input  logic [OFFSET_BITS-1:0] in_char_offset,
  output q_head_t                q_head,
  input  logic                   q_pop,
  output logic [HANDLE_BITS-1:0] q_handle,
  output logic [SIZE_BITS-1:0]   q_size,
  output logic [OFFSET_BITS-1:0] q_offset
);

  localparam int CMD_W = 1 + HANDLE_BITS + SIZE_BITS + OFFSET_BITS;

  logic [CMD_W-1:0]   ent_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wp_r, wp_nxt;
  logic [CMDQ_PW-1:0] rp_r, rp_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               push;
  logic               pop;
  logic [CMD_W-1:0]   head;

  assign in_ready = (cnt_r != CMDQ_CW'(CMDQ_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (cnt_r != '0);
  assign head     = ent_r[rp_r];

  assign q_head.valid = (cnt_r != '0);
  assign q_head.func  = func_t'(head[CMD_W-1]);
  assign q_handle     = head[CMD_W-2 -: HANDLE_BITS];
  assign q_size       = head[OFFSET_BITS +: SIZE_BITS];
  assign q_offset     = head[OFFSET_BITS-1:0];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= {in_func, in_entry_handle, in_entry_size, in_char_offset};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/wrol_back.sv @@
`timescale 1ns / 1ps

module wrol_back import wrol_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_head_t                q_head,
  output logic                   q_pop,
  input  logic [HANDLE_BITS-1:0] q_handle,
  input  logic [SIZE_BITS-1:0]   q_size,
  input  logic [OFFSET_BITS-1:0] q_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [HANDLE_BITS-1:0] out_hit_handle,
  output logic [SIZE_BITS-1:0]   out_hit_size,
  output logic [SIZE_BITS-1:0]   out_byte_in_entry,
  output logic                   out_overwrote
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REST_W = (SIZE_BITS > OFFSET_BITS) ? SIZE_BITS : OFFSET_BITS;
  localparam int REC_W  = HANDLE_BITS + SIZE_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   full_r, full_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [REST_W-1:0]      rest_r, rest_nxt;
  logic                   ov_r, ov_nxt;
  logic                   found_r, found_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [SIZE_BITS-1:0]   byte_r, byte_nxt;
  logic                   ovw_r, ovw_nxt;

  logic                   take;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [REC_W-1:0]       ram_rdata;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [SIZE_BITS-1:0]   rd_size;
  logic [IDX_W-1:0]       wr_next;
  logic [CNT_W-1:0]       live_cnt;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  wrol_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata({q_handle, q_size}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_handle = ram_rdata[REC_W-1 -: HANDLE_BITS];
  assign rd_size   = ram_rdata[SIZE_BITS-1:0];
  assign wr_next   = next_idx(wr_idx_r);
  assign ram_raddr = (state_r == ST_WALK) ? next_idx(idx_r) : rd_idx_r;
  assign take      = (state_r == ST_IDLE) && q_head.valid && (!out_valid || out_ready);
  assign q_pop     = take;
  assign ram_we    = take && (q_head.func == FN_ADD);

  always_comb begin
    if (full_r) begin
      live_cnt = CNT_W'(DEPTH);
    end else if (wr_idx_r >= rd_idx_r) begin
      live_cnt = CNT_W'(wr_idx_r) - CNT_W'(rd_idx_r);
    end else begin
      live_cnt = CNT_W'(wr_idx_r) + CNT_W'(DEPTH) - CNT_W'(rd_idx_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    full_nxt   = full_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    rest_nxt   = rest_r;
    ov_nxt     = out_valid && !out_ready;
    found_nxt  = found_r;
    handle_nxt = handle_r;
    size_nxt   = size_r;
    byte_nxt   = byte_r;
    ovw_nxt    = ovw_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_head.func == FN_ADD) begin
            wr_idx_nxt = wr_next;
            if (full_r) begin
              rd_idx_nxt = wr_next;
            end else if (wr_next == rd_idx_r) begin
              full_nxt = 1'b1;
            end
            ov_nxt     = 1'b1;
            found_nxt  = 1'b0;
            handle_nxt = '0;
            size_nxt   = '0;
            byte_nxt   = '0;
            ovw_nxt    = full_r;
          end else if (live_cnt == '0) begin
            ov_nxt     = 1'b1;
            found_nxt  = 1'b0;
            handle_nxt = '0;
            size_nxt   = '0;
            byte_nxt   = '0;
            ovw_nxt    = 1'b0;
          end else begin
            state_nxt = ST_WALK;
            idx_nxt   = rd_idx_r;
            cnt_nxt   = live_cnt;
            rest_nxt  = REST_W'(q_offset);
          end
        end
      end
      ST_WALK: begin
        if (rest_r < REST_W'(rd_size)) begin
          state_nxt  = ST_IDLE;
          ov_nxt     = 1'b1;
          found_nxt  = 1'b1;
          handle_nxt = rd_handle;
          size_nxt   = rd_size;
          byte_nxt   = rest_r[SIZE_BITS-1:0];
          ovw_nxt    = 1'b0;
        end else if (cnt_r == CNT_W'(1)) begin
          state_nxt  = ST_IDLE;
          ov_nxt     = 1'b1;
          found_nxt  = 1'b0;
          handle_nxt = '0;
          size_nxt   = '0;
          byte_nxt   = '0;
          ovw_nxt    = 1'b0;
        end else begin
          rest_nxt = rest_r - REST_W'(rd_size);
          idx_nxt  = next_idx(idx_r);
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    rest_r   <= rest_nxt;
    found_r  <= found_nxt;
    handle_r <= handle_nxt;
    size_r   <= size_nxt;
    byte_r   <= byte_nxt;
    ovw_r    <= ovw_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      full_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      full_r   <= full_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_found         = found_r;
  assign out_hit_handle    = handle_r;
  assign out_hit_size      = size_r;
  assign out_byte_in_entry = byte_r;
  assign out_overwrote     = ovw_r;

endmodule

@@ rtl/core/write_ring_offset_lookup_core.sv @@
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_func, in_entry_handle, in_entry_size, in_char_offset
// out      out_valid / out_ready  out_found, out_hit_handle, out_hit_size,
//                                 out_byte_in_entry, out_overwrote
//
// An add goes from acceptance into the command queue; the back end then writes the ring and registers the result.
// A lookup on an empty ring returns a miss without a walk; otherwise the walk reads one
// record a cycle from the ring RAM.
// Reset (rst_n low, synchronous) empties the ring and the command queue; no clearing pass.
// The 2-entry command queue keeps taking transactions, until it is full, while the back end walks or stalls.

module write_ring_offset_lookup_core import wrol_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [HANDLE_BITS-1:0] in_entry_handle,
  input  logic [SIZE_BITS-1:0]   in_entry_size,
  input  logic [OFFSET_BITS-1:0] in_char_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [HANDLE_BITS-1:0] out_hit_handle,
  output logic [SIZE_BITS-1:0]   out_hit_size,
  output logic [SIZE_BITS-1:0]   out_byte_in_entry,
  output logic                   out_overwrote
);

  q_head_t                q_head;
  logic                   q_pop;
  logic [HANDLE_BITS-1:0] q_handle;
  logic [SIZE_BITS-1:0]   q_size;
  logic [OFFSET_BITS-1:0] q_offset;

  wrol_front #(
    .SIZE_BITS  (SIZE_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_entry_handle(in_entry_handle),
    .in_entry_size  (in_entry_size),
    .in_char_offset (in_char_offset),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .q_handle       (q_handle),
    .q_size         (q_size),
    .q_offset       (q_offset)
  );

  wrol_back #(
    .DEPTH      (DEPTH),
    .SIZE_BITS  (SIZE_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .q_handle         (q_handle),
    .q_size           (q_size),
    .q_offset         (q_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_hit_handle   (out_hit_handle),
    .out_hit_size     (out_hit_size),
    .out_byte_in_entry(out_byte_in_entry),
    .out_overwrote    (out_overwrote)
  );

  a_found_xor_overwrote : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_overwrote))
    else $error("hit and overwrite reported together");

  a_hit_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_byte_in_entry < out_hit_size))
    else $error("byte offset outside hit record");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_hit_handle == '0 && out_hit_size == '0
                                   && out_byte_in_entry == '0))
    else $error("nonzero hit fields without a hit");

  a_pop_needs_head : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("command popped from empty queue");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import wrol_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int SIZE_W      = SIZE_BITS_DEF;
  localparam int HANDLE_W    = HANDLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 50;
  localparam int RAND_PER_PHASE = 225;

  typedef struct {
    func_t                fn;
    logic [HANDLE_W-1:0]  handle;
    logic [SIZE_W-1:0]    size;
    logic [OFFSET_BITS-1:0] offset;
  } ring_txn_t;

  typedef struct {
    logic                found;
    logic [HANDLE_W-1:0] hit_handle;
    logic [SIZE_W-1:0]   hit_size;
    logic [SIZE_W-1:0]   byte_in_entry;
    logic                overwrote;
  } ring_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_func;
  logic [HANDLE_W-1:0]    in_entry_handle;
  logic [SIZE_W-1:0]      in_entry_size;
  logic [OFFSET_BITS-1:0] in_char_offset;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_found;
  logic [HANDLE_W-1:0]    out_hit_handle;
  logic [SIZE_W-1:0]      out_hit_size;
  logic [SIZE_W-1:0]      out_byte_in_entry;
  logic                   out_overwrote;

  write_ring_offset_lookup_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_handle   (in_entry_handle),
    .in_entry_size     (in_entry_size),
    .in_char_offset    (in_char_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_hit_handle    (out_hit_handle),
    .out_hit_size      (out_hit_size),
    .out_byte_in_entry (out_byte_in_entry),
    .out_overwrote     (out_overwrote)
  );

  // predicted ring contents
  logic [HANDLE_W-1:0] rec_handle [DEPTH];
  logic [SIZE_W-1:0]   rec_size [DEPTH];
  int                  ring_wr;
  int                  ring_rd;
  logic                ring_full;

  ring_txn_t    tx_pending [$];
  ring_result_t expected_results [$];
  int unsigned  shadow_sizes [$];

  ring_txn_t    drv_txn;
  ring_txn_t    acc_txn;
  ring_result_t got_res;
  ring_result_t want_res;
  bit           in_taken;
  int           send_idle_pct;
  int           rcv_stall_pct;
  int           errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int next_idx(input int i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  // apply one transaction to the predicted ring, return its result
  function automatic ring_result_t ring_apply(input ring_txn_t t);
    ring_result_t           r;
    int                     cnt;
    int                     idx;
    int                     nxt;
    bit                     hit;
    logic [OFFSET_BITS-1:0] rest;
    r = '{default: '0};
    if (t.fn == FN_ADD) begin
      r.overwrote = ring_full;
      rec_handle[ring_wr] = t.handle;
      rec_size[ring_wr] = t.size;
      nxt = next_idx(ring_wr);
      if (ring_full) begin
        ring_rd = nxt;
      end else if (nxt == ring_rd) begin
        ring_full = 1'b1;
      end
      ring_wr = nxt;
    end else begin
      cnt = ring_full ? DEPTH : (ring_wr + DEPTH - ring_rd) % DEPTH;
      idx = ring_rd;
      rest = t.offset;
      hit = 1'b0;
      for (int k = 0; k < cnt; k++) begin
        if (!hit) begin
          if (rest < {{(OFFSET_BITS-SIZE_W){1'b0}}, rec_size[idx]}) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.hit_handle = rec_handle[idx];
            r.hit_size = rec_size[idx];
            r.byte_in_entry = rest[SIZE_W-1:0];
          end else begin
            rest = rest - {{(OFFSET_BITS-SIZE_W){1'b0}}, rec_size[idx]};
          end
          idx = next_idx(idx);
        end
      end
    end
    return r;
  endfunction

  task automatic queue_add(input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] s);
    tx_pending.push_back('{fn: FN_ADD, handle: h, size: s,
                           offset: OFFSET_BITS'($urandom)});
    shadow_sizes.push_back(s);
    if (shadow_sizes.size() > DEPTH) void'(shadow_sizes.pop_front());
  endtask

  task automatic queue_lookup(input logic [OFFSET_BITS-1:0] off);
    tx_pending.push_back('{fn: FN_LOOKUP, handle: HANDLE_W'($urandom),
                           size: SIZE_W'($urandom), offset: off});
  endtask

  task automatic queue_random();
    int unsigned total;
    int unsigned sz;
    int          pick;
    total = 0;
    foreach (shadow_sizes[i]) total += shadow_sizes[i];
    if ($urandom_range(99) < 40) begin
      pick = $urandom_range(9);
      case (pick)
        0: sz = 0;
        1: sz = $urandom_range(20'hfffff);
        2: sz = 20'hfffff;
        default: sz = $urandom_range(300, 1);
      endcase
      queue_add(HANDLE_W'($urandom), sz[SIZE_W-1:0]);
    end else begin
      pick = $urandom_range(9);
      case (pick)
        7: queue_lookup(total[OFFSET_BITS-1:0]);
        8: queue_lookup(OFFSET_BITS'($urandom));
        9: queue_lookup(OFFSET_BITS'((total > 0) ? total - 1 : 0));
        default: queue_lookup(OFFSET_BITS'($urandom_range(total)));
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                             input logic [HANDLE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (tx_pending.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (tx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_txn = tx_pending.pop_front();
        in_valid        <= 1'b1;
        in_func         <= drv_txn.fn;
        in_entry_handle <= drv_txn.handle;
        in_entry_size   <= drv_txn.size;
        in_char_offset  <= drv_txn.offset;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        acc_txn = '{fn: func_t'(in_func), handle: in_entry_handle, size: in_entry_size,
                    offset: in_char_offset};
        expected_results.push_back(ring_apply(acc_txn));
      end
      if (out_valid && out_ready) begin
        got_res = '{found: out_found, hit_handle: out_hit_handle, hit_size: out_hit_size,
                    byte_in_entry: out_byte_in_entry, overwrote: out_overwrote};
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: found=%0b handle=0x%0h",
                 out_found, out_hit_handle);
          errors++;
        end else begin
          want_res = expected_results.pop_front();
          check_field("found", HANDLE_W'(want_res.found), HANDLE_W'(got_res.found));
          check_field("hit_handle", want_res.hit_handle, got_res.hit_handle);
          check_field("hit_size", HANDLE_W'(want_res.hit_size),
                      HANDLE_W'(got_res.hit_size));
          check_field("byte_in_entry", HANDLE_W'(want_res.byte_in_entry),
                      HANDLE_W'(got_res.byte_in_entry));
          check_field("overwrote", HANDLE_W'(want_res.overwrote),
                      HANDLE_W'(got_res.overwrote));
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 51, 0, 11};
    stall_tab = '{0, 0, 51, 11};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FN_ADD;
    in_entry_handle = '0;
    in_entry_size   = '0;
    in_char_offset  = '0;
    out_ready       = 1'b0;
    in_taken        = 1'b0;
    send_idle_pct   = 0;
    rcv_stall_pct   = 0;
    errors          = 0;
    ring_wr         = 0;
    ring_rd         = 0;
    ring_full       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty ring, zero-size records, size extremes, boundaries
    queue_lookup(24'h000000);
    queue_lookup(24'hffffff);
    queue_add(32'h00000000, 20'h00000);
    queue_lookup(24'h000000);
    queue_add(32'hffffffff, 20'hfffff);
    queue_add(32'h12345678, 20'h00001);
    queue_add(32'ha5a5a5a5, 20'h00000);
    queue_add(32'h5a5a5a5a, 20'h0000a);
    queue_lookup(24'h000000);
    queue_lookup(24'h0ffffe);
    queue_lookup(24'h0fffff);
    queue_lookup(24'h100000);
    queue_lookup(24'h100009);
    queue_lookup(24'h10000a);
    queue_lookup(24'hffffff);
    queue_add(32'h80000000, 20'h80000);
    queue_lookup(24'h10000a);
    queue_lookup(24'h18000a);
    wait_drained();

    // random phases; each ends with the sender held until all results are in
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      rcv_stall_pct = stall_tab[p];
      repeat (RAND_PER_PHASE) queue_random();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
